// ===== rtl/ltpt_pkg.sv =====
// Shared types and constants of the line trim and punctuation tokenizer.
package ltpt_pkg;

    localparam int LTPT_MAX_LINE = 4096;
    localparam int TOK_W         = 13;
    localparam int KIND_W        = 5;
    localparam int MAX_RES       = 4;
    localparam int CNT_W         = $clog2(MAX_RES + 1);
    localparam int RES_IW        = $clog2(MAX_RES);

    typedef logic [KIND_W-1:0] t_tkind;

    localparam t_tkind TK_NORMAL   = 5'd0;
    localparam t_tkind TK_LCOMMENT = 5'd1;
    localparam t_tkind TK_SEMI     = 5'd2;
    localparam t_tkind TK_OCOMMENT = 5'd3;
    localparam t_tkind TK_CCOMMENT = 5'd4;
    localparam t_tkind TK_TRIPLE   = 5'd5;
    localparam t_tkind TK_QUOTE    = 5'd6;
    localparam t_tkind TK_ESCAPE   = 5'd7;
    localparam t_tkind TK_COLON    = 5'd8;
    localparam t_tkind TK_LPAREN   = 5'd9;
    localparam t_tkind TK_RPAREN   = 5'd10;
    localparam t_tkind TK_LBRACK   = 5'd11;
    localparam t_tkind TK_RBRACK   = 5'd12;
    localparam t_tkind TK_LBRACE   = 5'd13;
    localparam t_tkind TK_RBRACE   = 5'd14;
    localparam t_tkind TK_COMMA    = 5'd15;
    localparam t_tkind TK_EOL      = 5'd16;

    typedef enum logic [3:0] {
        PK_NONE  = 4'd0,
        PK_SLASH = 4'd1,
        PK_STAR  = 4'd2,
        PK_Q1    = 4'd3,
        PK_Q2    = 4'd4,
        PK_BSL   = 4'd5,
        PK_OCT   = 4'd6,
        PK_X0    = 4'd7,
        PK_XN    = 4'd8,
        PK_U4    = 4'd9,
        PK_U8    = 4'd10
    } t_pkind;

    typedef struct packed {
        t_tkind             token_kind;
        logic [TOK_W-1:0]   token_column;
        logic [TOK_W-1:0]   token_length;
        logic [TOK_W-1:0]   leading_length;
        logic               line_empty;
        logic               last;
    } t_result;

    typedef struct packed {
        t_result [MAX_RES-1:0] res;
        logic [CNT_W-1:0]      cnt;
    } t_burst;

endpackage

// ===== rtl/ltpt_in_if.sv =====
// Input channel: one line byte per beat.
interface ltpt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       has_byte;
    logic       end_of_line;

    modport source (output valid, char_byte, has_byte, end_of_line, input ready);
    modport sink   (input valid, char_byte, has_byte, end_of_line, output ready);
endinterface

// ===== rtl/ltpt_out_if.sv =====
// Output channel: one token per beat.
interface ltpt_out_if;
    import ltpt_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  token_kind;
    logic [TOK_W-1:0]   token_column;
    logic [TOK_W-1:0]   token_length;
    logic [TOK_W-1:0]   leading_length;
    logic               line_empty;
    logic               last;

    modport source (output valid, token_kind, token_column, token_length, leading_length,
                    line_empty, last, input ready);
    modport sink   (input valid, token_kind, token_column, token_length, leading_length,
                    line_empty, last, output ready);
endinterface

// ===== rtl/ltpt_step.sv =====
// Line state register and the per-byte trim and tokenize logic.
module ltpt_step #(
    parameter int MAX_LINE = ltpt_pkg::LTPT_MAX_LINE
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  logic [7:0]      i_char,
    input  logic            i_has,
    input  logic            i_eol,
    output ltpt_pkg::t_burst o_burst
);
    import ltpt_pkg::*;

    localparam int LW = $clog2(MAX_LINE + 1);
    localparam logic [LW-1:0] MAX_COL = LW'(MAX_LINE);

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSL    = 8'h5C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LX     = 8'h78;
    localparam logic [7:0] CH_LU     = 8'h75;
    localparam logic [7:0] CH_UU     = 8'h55;

    typedef struct packed {
        logic [LW-1:0] column;
        logic          in_leading;
        logic [LW-1:0] leading_count;
        logic [LW-1:0] normal_start;
        logic [LW-1:0] normal_count;
        logic [LW-1:0] trail_run;
        t_pkind        pk;
        logic [LW-1:0] pstart;
        logic [3:0]    pdigits;
    } t_state;

    typedef struct packed {
        t_state s;
        t_burst o;
    } t_ctx;

    t_state r_state;
    t_ctx   n_ctx;

    function automatic t_state f_reset_state();
        t_state s;
        s.column        = '0;
        s.in_leading    = 1'b1;
        s.leading_count = '0;
        s.normal_start  = '0;
        s.normal_count  = '0;
        s.trail_run     = '0;
        s.pk            = PK_NONE;
        s.pstart        = '0;
        s.pdigits       = '0;
        return s;
    endfunction

    function automatic logic f_is_oct(logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h37);
    endfunction

    function automatic logic f_is_hex(logic [7:0] b);
        return ((b >= 8'h30) && (b <= 8'h39)) || ((b >= 8'h41) && (b <= 8'h46)) ||
               ((b >= 8'h61) && (b <= 8'h66));
    endfunction

    function automatic logic f_is_single(logic [7:0] b);
        return (b == 8'h22) || (b == 8'h74) || (b == 8'h6E) || (b == 8'h72) ||
               (b == 8'h5C) || (b == 8'h62) || (b == 8'h66) || (b == 8'h76) ||
               (b == 8'h61) || (b == 8'h27) || (b == 8'h3F);
    endfunction

    function automatic t_ctx f_put(t_ctx c, t_tkind k, logic [LW-1:0] col,
                                   logic [LW-1:0] len, logic [LW-1:0] lead,
                                   logic empty, logic lst);
        t_result r;
        r.token_kind     = k;
        r.token_column   = TOK_W'(col);
        r.token_length   = TOK_W'(len);
        r.leading_length = TOK_W'(lead);
        r.line_empty     = empty;
        r.last           = lst;
        if (c.o.cnt < CNT_W'(MAX_RES)) begin
            c.o.res[c.o.cnt[RES_IW-1:0]] = r;
            c.o.cnt = c.o.cnt + CNT_W'(1);
        end
        return c;
    endfunction

    function automatic t_ctx f_flush(t_ctx c);
        if (c.s.normal_count != '0) begin
            c = f_put(c, TK_NORMAL, c.s.normal_start, c.s.normal_count, '0, 1'b0, 1'b0);
        end
        c.s.normal_count = '0;
        return c;
    endfunction

    function automatic t_ctx f_add(t_ctx c, logic [LW-1:0] start, logic [LW-1:0] len);
        if (len != '0) begin
            if (c.s.normal_count == '0) begin
                c.s.normal_start = start;
            end
            c.s.normal_count = c.s.normal_count + len;
        end
        return c;
    endfunction

    function automatic t_ctx f_finish(t_ctx c, t_tkind k, logic [LW-1:0] len);
        c = f_flush(c);
        c = f_put(c, k, c.s.pstart, len, '0, 1'b0, 1'b0);
        c.s.pk      = PK_NONE;
        c.s.pdigits = '0;
        return c;
    endfunction

    function automatic t_ctx f_resolve(t_ctx c, logic [LW-1:0] pos);
        logic [LW-1:0] plen;
        plen = pos - c.s.pstart;
        case (c.s.pk)
            PK_Q1: begin
                c = f_put(c, TK_QUOTE, c.s.pstart, LW'(1), '0, 1'b0, 1'b0);
            end
            PK_Q2: begin
                c = f_put(c, TK_QUOTE, c.s.pstart, LW'(1), '0, 1'b0, 1'b0);
                c = f_put(c, TK_QUOTE, c.s.pstart + LW'(1), LW'(1), '0, 1'b0, 1'b0);
            end
            PK_OCT, PK_XN: begin
                c = f_flush(c);
                c = f_put(c, TK_ESCAPE, c.s.pstart, plen, '0, 1'b0, 1'b0);
            end
            PK_NONE: begin
            end
            default: begin
                c = f_add(c, c.s.pstart, plen);
            end
        endcase
        c.s.pk      = PK_NONE;
        c.s.pdigits = '0;
        return c;
    endfunction

    function automatic t_ctx f_start(t_ctx c, t_pkind k, logic [LW-1:0] pos);
        c.s.pk      = k;
        c.s.pstart  = pos;
        c.s.pdigits = '0;
        return c;
    endfunction

    function automatic t_ctx f_fresh(t_ctx c, logic [7:0] b, logic [LW-1:0] pos);
        t_tkind k;
        logic   punct;
        k     = TK_NORMAL;
        punct = 1'b1;
        unique case (b)
            CH_SLASH: begin
                punct = 1'b0;
                c = f_start(c, PK_SLASH, pos);
            end
            CH_STAR: begin
                punct = 1'b0;
                c = f_start(c, PK_STAR, pos);
            end
            CH_QUOTE: begin
                punct = 1'b0;
                c = f_flush(c);
                c = f_start(c, PK_Q1, pos);
            end
            CH_BSL: begin
                punct = 1'b0;
                c = f_start(c, PK_BSL, pos);
            end
            CH_SEMI:   k = TK_SEMI;
            CH_COLON:  k = TK_COLON;
            CH_LPAREN: k = TK_LPAREN;
            CH_RPAREN: k = TK_RPAREN;
            CH_LBRACK: k = TK_LBRACK;
            CH_RBRACK: k = TK_RBRACK;
            CH_LBRACE: k = TK_LBRACE;
            CH_RBRACE: k = TK_RBRACE;
            CH_COMMA:  k = TK_COMMA;
            default: begin
                punct = 1'b0;
                c = f_add(c, pos, LW'(1));
            end
        endcase
        if (punct) begin
            c = f_flush(c);
            c = f_put(c, k, pos, LW'(1), '0, 1'b0, 1'b0);
        end
        return c;
    endfunction

    function automatic t_ctx f_text(t_ctx c, logic [7:0] b, logic [LW-1:0] pos);
        logic hit;
        hit = 1'b0;
        case (c.s.pk)
            PK_SLASH: begin
                if (b == CH_SLASH) begin
                    hit = 1'b1;
                    c = f_finish(c, TK_LCOMMENT, LW'(2));
                end else if (b == CH_STAR) begin
                    hit = 1'b1;
                    c = f_finish(c, TK_OCOMMENT, LW'(2));
                end
            end
            PK_STAR: begin
                if (b == CH_SLASH) begin
                    hit = 1'b1;
                    c = f_finish(c, TK_CCOMMENT, LW'(2));
                end
            end
            PK_Q1: begin
                if (b == CH_QUOTE) begin
                    hit = 1'b1;
                    c.s.pk = PK_Q2;
                end
            end
            PK_Q2: begin
                if (b == CH_QUOTE) begin
                    hit = 1'b1;
                    c = f_finish(c, TK_TRIPLE, LW'(3));
                end
            end
            PK_BSL: begin
                if (f_is_oct(b)) begin
                    hit = 1'b1;
                    c.s.pk      = PK_OCT;
                    c.s.pdigits = 4'd1;
                end else if (b == CH_LX) begin
                    hit = 1'b1;
                    c.s.pk = PK_X0;
                end else if (b == CH_LU) begin
                    hit = 1'b1;
                    c.s.pk      = PK_U4;
                    c.s.pdigits = '0;
                end else if (b == CH_UU) begin
                    hit = 1'b1;
                    c.s.pk      = PK_U8;
                    c.s.pdigits = '0;
                end else if (f_is_single(b)) begin
                    hit = 1'b1;
                    c = f_finish(c, TK_ESCAPE, LW'(2));
                end
            end
            PK_OCT: begin
                if (f_is_oct(b)) begin
                    hit = 1'b1;
                    c.s.pdigits = c.s.pdigits + 4'd1;
                    if (c.s.pdigits >= 4'd3) begin
                        c = f_finish(c, TK_ESCAPE, LW'(4));
                    end
                end
            end
            PK_X0: begin
                if (f_is_hex(b)) begin
                    hit = 1'b1;
                    c.s.pk = PK_XN;
                end
            end
            PK_XN: begin
                if (f_is_hex(b)) begin
                    hit = 1'b1;
                end
            end
            PK_U4: begin
                if (f_is_hex(b)) begin
                    hit = 1'b1;
                    c.s.pdigits = c.s.pdigits + 4'd1;
                    if (c.s.pdigits >= 4'd4) begin
                        c = f_finish(c, TK_ESCAPE, LW'(6));
                    end
                end
            end
            PK_U8: begin
                if (f_is_hex(b)) begin
                    hit = 1'b1;
                    c.s.pdigits = c.s.pdigits + 4'd1;
                    if (c.s.pdigits >= 4'd8) begin
                        c = f_finish(c, TK_ESCAPE, LW'(10));
                    end
                end
            end
            default: begin
            end
        endcase
        if (!hit) begin
            if (c.s.pk != PK_NONE) begin
                c = f_resolve(c, pos);
            end
            c = f_fresh(c, b, pos);
        end
        return c;
    endfunction

    function automatic t_ctx f_step(t_state s, logic [7:0] b, logic has, logic eol);
        t_ctx          c;
        logic [LW-1:0] pos;
        logic [LW-1:0] size;
        logic [LW-1:0] cut;
        logic [LW-1:0] tlen;
        logic [LW-1:0] nlen;
        logic [LW:0]   sum;
        c.s     = s;
        c.o.res = '0;
        c.o.cnt = '0;
        pos     = '0;
        nlen    = '0;
        if (has && (s.column < MAX_COL)) begin
            pos = c.s.column;
            if (b == CH_SPACE) begin
                c.s.trail_run = c.s.trail_run + LW'(1);
            end else if (b == CH_TAB) begin
                c.s.trail_run = LW'(1);
            end else begin
                c.s.trail_run = '0;
            end
            if (c.s.in_leading && (b == CH_SPACE)) begin
                c.s.leading_count = c.s.leading_count + LW'(1);
            end else if (c.s.in_leading && (b == CH_TAB)) begin
                c.s.leading_count = c.s.leading_count + LW'(1);
                c.s.in_leading    = 1'b0;
            end else begin
                c.s.in_leading = 1'b0;
                c = f_text(c, b, pos);
            end
            c.s.column = c.s.column + LW'(1);
        end
        if (eol) begin
            size = c.s.column;
            c    = f_resolve(c, size);
            sum  = {1'b0, c.s.leading_count} + {1'b0, c.s.trail_run};
            if (sum > {1'b0, size}) begin
                cut  = '0;
                tlen = size - c.s.leading_count;
            end else begin
                cut  = c.s.trail_run;
                tlen = size - c.s.leading_count - c.s.trail_run;
            end
            if (c.s.normal_count != '0) begin
                nlen = (cut > c.s.normal_count) ? '0 : (c.s.normal_count - cut);
                if (nlen != '0) begin
                    c = f_put(c, TK_NORMAL, c.s.normal_start, nlen, '0, 1'b0, 1'b0);
                end
                c.s.normal_count = '0;
            end
            c = f_put(c, TK_EOL, c.s.leading_count, tlen, c.s.leading_count,
                      (tlen == '0), 1'b1);
            c.s = f_reset_state();
        end
        return c;
    endfunction

    always_comb begin
        n_ctx = f_step(r_state, i_char, i_has, i_eol);
    end

    assign o_burst = n_ctx.o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= f_reset_state();
        end else if (i_fire) begin
            r_state <= n_ctx.s;
        end
    end

endmodule

// ===== rtl/line_trim_and_punctuation_tokenizer.sv =====
// Line trim and punctuation tokenizer top level: input register, step logic, result buffer.
//
// Bytes of a source line enter one per beat; leading spaces and one tab, and trailing spaces
// with at most one tab before them, are trimmed, and the rest is split into punctuation,
// comment, quote and escape tokens with normal text between them, each reported by kind,
// column and length, followed by an end-of-line token. A beat is held in an input register,
// processed by the step logic, and its up to four tokens are loaded into a four-entry result
// buffer that shifts out one token per cycle while the output is ready. A new beat is taken
// every cycle while each beat yields at most one token and the output is ready; a beat with
// more tokens holds off the next beat until its last token is taken. A beat's tokens appear
// after the input register and the result buffer. Bytes beyond MAX_LINE in a line are dropped.
module line_trim_and_punctuation_tokenizer #(
    parameter int MAX_LINE = ltpt_pkg::LTPT_MAX_LINE
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ltpt_in_if.sink    i_in,
    ltpt_out_if.source o_out
);
    import ltpt_pkg::*;

    logic                    r_in_valid;
    logic [7:0]              r_char;
    logic                    r_has;
    logic                    r_eol;
    t_result [MAX_RES-1:0]   r_res;
    logic [CNT_W-1:0]        r_cnt;
    t_burst                  n_burst;
    logic                    take;
    logic                    buf_free;
    logic                    fire;

    assign take     = (r_cnt != '0) && o_out.ready;
    assign buf_free = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && take);
    assign fire     = r_in_valid && buf_free;
    assign i_in.ready = !r_in_valid || fire;

    ltpt_step #(
        .MAX_LINE (MAX_LINE)
    ) u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_char  (r_char),
        .i_has   (r_has),
        .i_eol   (r_eol),
        .o_burst (n_burst)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_cnt      <= '0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_cnt <= n_burst.cnt;
            end else if (take) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_char <= i_in.char_byte;
            r_has  <= i_in.has_byte;
            r_eol  <= i_in.end_of_line;
        end
        if (fire) begin
            r_res <= n_burst.res;
        end else if (take) begin
            for (int i = 0; i < MAX_RES - 1; i++) begin
                r_res[i] <= r_res[i+1];
            end
        end
    end

    assign o_out.valid          = (r_cnt != '0);
    assign o_out.token_kind     = r_res[0].token_kind;
    assign o_out.token_column   = r_res[0].token_column;
    assign o_out.token_length   = r_res[0].token_length;
    assign o_out.leading_length = r_res[0].leading_length;
    assign o_out.line_empty     = r_res[0].line_empty;
    assign o_out.last           = r_res[0].last;

    a_eol_closes_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_eol |=> (r_cnt != '0) && r_res[RES_IW'(r_cnt - CNT_W'(1))].last)
        else $error("end-of-line beat did not end its burst with a last token");

    a_no_load_over_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt > CNT_W'(1)) |-> !fire)
        else $error("result buffer loaded while tokens were pending");

    a_last_is_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.last |-> (o_out.token_kind == TK_EOL))
        else $error("last flag on a token that is not end of line");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && !fire |=> (r_cnt == $past(r_cnt) - CNT_W'(1)))
        else $error("result count did not drop after a token was taken");

endmodule

// ===== test/tb_line_trim_and_punctuation_tokenizer.sv =====
// Testbench for the line trim and punctuation tokenizer: directed and random lines.
`timescale 1ns / 100ps

module tb_line_trim_and_punctuation_tokenizer;
    import ltpt_pkg::*;

    logic clk = 1'b0;
    logic rst_n;

    ltpt_in_if  in_ch ();
    ltpt_out_if out_ch ();

    line_trim_and_punctuation_tokenizer dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always #1 clk = ~clk;

    // Token predictor state
    int unsigned ln_col;
    bit          in_lead;
    int unsigned lead_cnt;
    int unsigned norm_start;
    int unsigned norm_cnt;
    int unsigned trail_run;
    t_pkind      part_kind;
    int unsigned part_start;
    int unsigned part_digits;
    int unsigned step_cnt;

    t_result     pending_tokens[$];
    logic [7:0]  line_q[$];
    int          mismatch_cnt = 0;
    int          beats_sent = 0;
    bit          free_run = 1'b0;
    int          stall_left = 0;

    function automatic void clear_line();
        ln_col      = 0;
        in_lead     = 1'b1;
        lead_cnt    = 0;
        norm_start  = 0;
        norm_cnt    = 0;
        trail_run   = 0;
        part_kind   = PK_NONE;
        part_start  = 0;
        part_digits = 0;
    endfunction

    function automatic void push_token(t_tkind kind, int unsigned col, int unsigned len,
                                       int unsigned lead, bit empty, bit lst);
        t_result r;
        if (step_cnt >= MAX_RES) return;
        r.token_kind     = kind;
        r.token_column   = TOK_W'(col);
        r.token_length   = TOK_W'(len);
        r.leading_length = TOK_W'(lead);
        r.line_empty     = empty;
        r.last           = lst;
        pending_tokens.insert(pending_tokens.size(), r);
        step_cnt++;
    endfunction

    function automatic void flush_text();
        if (norm_cnt != 0) push_token(TK_NORMAL, norm_start, norm_cnt, 0, 1'b0, 1'b0);
        norm_cnt = 0;
    endfunction

    function automatic void extend_text(int unsigned start, int unsigned len);
        if (len == 0) return;
        if (norm_cnt == 0) norm_start = start;
        norm_cnt += len;
    endfunction

    function automatic void complete_partial(t_tkind kind, int unsigned len);
        flush_text();
        push_token(kind, part_start, len, 0, 1'b0, 1'b0);
        part_kind   = PK_NONE;
        part_digits = 0;
    endfunction

    function automatic bit oct_digit(logic [7:0] b);
        return b >= "0" && b <= "7";
    endfunction

    function automatic bit hex_digit(logic [7:0] b);
        return (b >= "0" && b <= "9") || (b >= "A" && b <= "F") || (b >= "a" && b <= "f");
    endfunction

    function automatic bit simple_escape(logic [7:0] b);
        return b == "\"" || b == "t" || b == "n" || b == "r" || b == "\\" || b == "b" ||
               b == "f" || b == "v" || b == "a" || b == "'" || b == "?";
    endfunction

    function automatic void settle_partial(int unsigned pos);
        int unsigned plen;
        plen = pos - part_start;
        case (part_kind)
            PK_Q1: push_token(TK_QUOTE, part_start, 1, 0, 1'b0, 1'b0);
            PK_Q2: begin
                push_token(TK_QUOTE, part_start, 1, 0, 1'b0, 1'b0);
                push_token(TK_QUOTE, part_start + 1, 1, 0, 1'b0, 1'b0);
            end
            PK_OCT, PK_XN: begin
                flush_text();
                push_token(TK_ESCAPE, part_start, plen, 0, 1'b0, 1'b0);
            end
            PK_NONE: ;
            default: extend_text(part_start, plen);
        endcase
        part_kind   = PK_NONE;
        part_digits = 0;
    endfunction

    function automatic void open_partial(t_pkind kind, int unsigned pos);
        part_kind   = kind;
        part_start  = pos;
        part_digits = 0;
    endfunction

    function automatic void plain_byte(logic [7:0] b, int unsigned pos);
        t_tkind kind;
        case (b)
            "/": begin
                open_partial(PK_SLASH, pos);
                return;
            end
            "*": begin
                open_partial(PK_STAR, pos);
                return;
            end
            "\"": begin
                flush_text();
                open_partial(PK_Q1, pos);
                return;
            end
            "\\": begin
                open_partial(PK_BSL, pos);
                return;
            end
            ";": kind = TK_SEMI;
            ":": kind = TK_COLON;
            "(": kind = TK_LPAREN;
            ")": kind = TK_RPAREN;
            "[": kind = TK_LBRACK;
            "]": kind = TK_RBRACK;
            "{": kind = TK_LBRACE;
            "}": kind = TK_RBRACE;
            ",": kind = TK_COMMA;
            default: begin
                extend_text(pos, 1);
                return;
            end
        endcase
        flush_text();
        push_token(kind, pos, 1, 0, 1'b0, 1'b0);
    endfunction

    function automatic void scan_byte(logic [7:0] b, int unsigned pos);
        case (part_kind)
            PK_SLASH: begin
                if (b == "/") begin
                    complete_partial(TK_LCOMMENT, 2);
                    return;
                end
                if (b == "*") begin
                    complete_partial(TK_OCOMMENT, 2);
                    return;
                end
            end
            PK_STAR: if (b == "/") begin
                complete_partial(TK_CCOMMENT, 2);
                return;
            end
            PK_Q1: if (b == "\"") begin
                part_kind = PK_Q2;
                return;
            end
            PK_Q2: if (b == "\"") begin
                complete_partial(TK_TRIPLE, 3);
                return;
            end
            PK_BSL: begin
                if (oct_digit(b)) begin
                    part_kind   = PK_OCT;
                    part_digits = 1;
                    return;
                end
                if (b == "x") begin
                    part_kind = PK_X0;
                    return;
                end
                if (b == "u") begin
                    part_kind   = PK_U4;
                    part_digits = 0;
                    return;
                end
                if (b == "U") begin
                    part_kind   = PK_U8;
                    part_digits = 0;
                    return;
                end
                if (simple_escape(b)) begin
                    complete_partial(TK_ESCAPE, 2);
                    return;
                end
            end
            PK_OCT: if (oct_digit(b)) begin
                part_digits++;
                if (part_digits >= 3) complete_partial(TK_ESCAPE, 4);
                return;
            end
            PK_X0: if (hex_digit(b)) begin
                part_kind = PK_XN;
                return;
            end
            PK_XN: if (hex_digit(b)) return;
            PK_U4: if (hex_digit(b)) begin
                part_digits++;
                if (part_digits >= 4) complete_partial(TK_ESCAPE, 6);
                return;
            end
            PK_U8: if (hex_digit(b)) begin
                part_digits++;
                if (part_digits >= 8) complete_partial(TK_ESCAPE, 10);
                return;
            end
            default: ;
        endcase
        if (part_kind != PK_NONE) settle_partial(pos);
        plain_byte(b, pos);
    endfunction

    function automatic void predict_tokens(logic [7:0] b, logic hb, logic eol);
        int unsigned cut;
        int unsigned tlen;
        int unsigned keep;
        step_cnt = 0;
        if (hb && ln_col < LTPT_MAX_LINE) begin
            if (b == " ") trail_run++;
            else if (b == "\t") trail_run = 1;
            else trail_run = 0;
            if (in_lead && b == " ") begin
                lead_cnt++;
            end else if (in_lead && b == "\t") begin
                lead_cnt++;
                in_lead = 1'b0;
            end else begin
                in_lead = 1'b0;
                scan_byte(b, ln_col);
            end
            ln_col++;
        end
        if (eol) begin
            settle_partial(ln_col);
            if (lead_cnt + trail_run > ln_col) begin
                cut  = 0;
                tlen = ln_col - lead_cnt;
            end else begin
                cut  = trail_run;
                tlen = ln_col - lead_cnt - trail_run;
            end
            if (norm_cnt != 0) begin
                keep = (cut > norm_cnt) ? 0 : norm_cnt - cut;
                if (keep != 0) push_token(TK_NORMAL, norm_start, keep, 0, 1'b0, 1'b0);
                norm_cnt = 0;
            end
            push_token(TK_EOL, lead_cnt, tlen, lead_cnt, tlen == 0, 1'b1);
            clear_line();
        end
    endfunction

    function automatic int idle_gap();
        int r;
        if (free_run) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic int stall_len();
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    task automatic send_beat(input logic [7:0] b, input logic hb, input logic eol);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.char_byte   <= b;
        in_ch.has_byte    <= hb;
        in_ch.end_of_line <= eol;
        @(posedge clk);
        while (in_ch.ready !== 1'b1) @(posedge clk);
        predict_tokens(b, hb, eol);
        @(negedge clk);
    endtask

    task automatic send_line(input bit eol_on_byte);
        foreach (line_q[i]) begin
            if ($urandom_range(0, 49) == 0) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_beat(line_q[i], 1'b1, eol_on_byte && i == line_q.size() - 1);
        end
        if (!eol_on_byte || line_q.size() == 0) begin
            send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            beats_sent++;
        end
        beats_sent += line_q.size();
    endtask

    function automatic void append_byte(logic [7:0] b);
        line_q.insert(line_q.size(), b);
    endfunction

    function automatic void add_str(string s);
        foreach (s[i]) append_byte(s[i]);
    endfunction

    task automatic send_text(input string s, input bit eol_on_byte);
        line_q.delete();
        add_str(s);
        send_line(eol_on_byte);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(negedge clk); while (pending_tokens.size() != 0);
    endtask

    function automatic logic [7:0] rand_hex();
        string digits;
        digits = "0123456789abcdefABCDEF";
        return digits[$urandom_range(0, 21)];
    endfunction

    function automatic void add_escape();
        string singles;
        int    n;
        singles = "\"tnr\\bfva'?q8";
        append_byte("\\");
        case ($urandom_range(0, 4))
            0: begin
                n = $urandom_range(1, 4);
                repeat (n) append_byte(8'("0" + $urandom_range(0, 7)));
            end
            1: begin
                append_byte("x");
                n = $urandom_range(0, 3);
                repeat (n) append_byte(rand_hex());
            end
            2: begin
                append_byte("u");
                n = $urandom_range(0, 5);
                repeat (n) append_byte(rand_hex());
            end
            3: begin
                append_byte("U");
                n = $urandom_range(0, 9);
                repeat (n) append_byte(rand_hex());
            end
            default: append_byte(singles[$urandom_range(0, singles.len() - 1)]);
        endcase
    endfunction

    function automatic void add_fragment();
        string punct;
        string stray;
        int    n;
        punct = ";:()[]{},";
        stray = "/*\\";
        case ($urandom_range(0, 11))
            0: add_str("//");
            1: add_str("/*");
            2: add_str("*/");
            3: add_str("\"\"\"");
            4: add_str("\"");
            5: add_escape();
            6: append_byte(punct[$urandom_range(0, punct.len() - 1)]);
            7, 8: begin
                n = $urandom_range(1, 5);
                repeat (n) append_byte(8'("a" + $urandom_range(0, 25)));
            end
            9: begin
                n = $urandom_range(1, 3);
                repeat (n) append_byte($urandom_range(0, 1) ? " " : "\t");
            end
            10: append_byte(8'($urandom_range(0, 255)));
            default: append_byte(stray[$urandom_range(0, 2)]);
        endcase
    endfunction

    function automatic void build_random_line();
        int n;
        line_q.delete();
        n = $urandom_range(0, 3);
        repeat (n) append_byte(" ");
        if ($urandom_range(0, 9) < 4) append_byte("\t");
        n = $urandom_range(0, 6);
        repeat (n) add_fragment();
        if ($urandom_range(0, 1)) append_byte("\t");
        n = $urandom_range(0, 3);
        repeat (n) append_byte(" ");
    endfunction

    task automatic test_punctuation();
        send_text("\t;:()[]{},//x", 1'b1);
    endtask

    task automatic test_quotes_and_comments();
        send_text("  ab\"\"\"c\"/*d*/ x*y/z ", 1'b1);
        send_text("\"\"k\"\"", 1'b0);
    endtask

    task automatic test_escapes();
        send_text("\\101\\18\\x1fG\\uBEEF\\U0123abcd\\n\\q", 1'b1);
        send_text("\\x\\u12\\U\\", 1'b0);
    endtask

    task automatic test_trim();
        send_text("  \t  ", 1'b1);
        send_text(" \t a \t  ", 1'b1);
        send_text("   ", 1'b0);
        send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        wait_drained();
    endtask

    task automatic test_random();
        int target;
        target = beats_sent + 250;
        while (beats_sent < target) begin
            free_run = ($urandom_range(0, 7) == 0);
            build_random_line();
            send_line($urandom_range(0, 9) < 7);
        end
        free_run = 1'b0;
    endtask

    always @(negedge clk) begin
        if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else begin
            out_ch.ready <= 1'b1;
            if (!free_run && $urandom_range(0, 99) < 25) stall_left <= stall_len();
        end
    end

    function automatic void check_field(string name, logic [TOK_W-1:0] want,
                                        logic [TOK_W-1:0] got);
        if (got !== want) begin
            mismatch_cnt++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk) begin
        t_result want;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (pending_tokens.size() == 0) begin
                mismatch_cnt++;
                $display("%0t: unexpected token kind %0d column %0d length %0d", $time,
                         out_ch.token_kind, out_ch.token_column, out_ch.token_length);
            end else begin
                want = pending_tokens.pop_front();
                check_field("token_kind", TOK_W'(want.token_kind), TOK_W'(out_ch.token_kind));
                check_field("token_column", want.token_column, out_ch.token_column);
                check_field("token_length", want.token_length, out_ch.token_length);
                check_field("leading_length", want.leading_length, out_ch.leading_length);
                check_field("line_empty", TOK_W'(want.line_empty), TOK_W'(out_ch.line_empty));
                check_field("last", TOK_W'(want.last), TOK_W'(out_ch.last));
            end
        end
    end

    initial begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        in_ch.valid       = 1'b0;
        in_ch.char_byte   = 8'd0;
        in_ch.has_byte    = 1'b0;
        in_ch.end_of_line = 1'b0;
        out_ch.ready      = 1'b0;
        rst_n             = 1'b0;
        clear_line();
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_punctuation();
        test_quotes_and_comments();
        test_escapes();
        test_trim();
        test_random();

        wait_drained();
        repeat (20) @(negedge clk);
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
